### hdl/bcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared widths, register indexes, reset values and the tally record that
// travels from the counting front end through the queue to the test stage.
// ----------------------------------------------------------------------------
package bcf_pkg;

    // Counter width (range 8 to 48)
    localparam int COUNT_BITS = 32;

    localparam int CUT_W   = 16;                 // cutoff registers, Q0.16
    localparam int LEN_W   = 32;                 // min_length register
    localparam int OUT_W   = 32;                 // result count fields
    localparam int CFG_W   = 32;                 // config write data
    localparam int IDX_W   = 2;                  // config register index
    localparam int PROD_W  = COUNT_BITS + CUT_W; // cutoff * length
    localparam int CMP_W   = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    // Queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_LO_BOUND   = 2'd0;
    localparam logic [IDX_W-1:0] REG_HI_BOUND   = 2'd1;
    localparam logic [IDX_W-1:0] REG_MIN_LENGTH = 2'd2;

    // Reset values: 0.15 and 0.40 in Q0.16, truncated
    localparam logic [CUT_W-1:0] LO_BOUND_RST   = 16'd9830;
    localparam logic [CUT_W-1:0] HI_BOUND_RST   = 16'd26214;
    localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 32'd1000;

    // Finished tallies of one sequence
    typedef struct packed {
        logic [COUNT_BITS-1:0] len;
        logic [COUNT_BITS-1:0] a;
        logic [COUNT_BITS-1:0] c;
        logic [COUNT_BITS-1:0] g;
        logic [COUNT_BITS-1:0] t;
        logic [COUNT_BITS-1:0] n;
    } tally_snap_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage
`default_nettype wire

### hdl/bcf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_front
// Classify each character beat, bump the saturating tallies, and push the
// finished tallies into the queue on the last character of a sequence.
// ----------------------------------------------------------------------------
module bcf_front
(
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  logic                  in_valid,
    output logic                        in_stall,
    input  wire  logic [7:0]            base_char,
    input  wire  logic                  seq_end,
    input  wire  bcf_pkg::q_stat_t      q_stat,
    output logic                        push,
    output bcf_pkg::tally_snap_t        push_data
);

    typedef enum logic [2:0] {
        CLS_A,
        CLS_C,
        CLS_G,
        CLS_T,
        CLS_N,
        CLS_OTHER
    } base_class_t;

    localparam logic [7:0] CH_A_LO = "a";
    localparam logic [7:0] CH_A_UP = "A";
    localparam logic [7:0] CH_C_LO = "c";
    localparam logic [7:0] CH_C_UP = "C";
    localparam logic [7:0] CH_G_LO = "g";
    localparam logic [7:0] CH_G_UP = "G";
    localparam logic [7:0] CH_T_LO = "t";
    localparam logic [7:0] CH_T_UP = "T";
    localparam logic [7:0] CH_N_LO = "n";
    localparam logic [7:0] CH_N_UP = "N";

    function automatic logic [bcf_pkg::COUNT_BITS-1:0] sat_inc(
        input logic [bcf_pkg::COUNT_BITS-1:0] v
    );
        logic [bcf_pkg::COUNT_BITS-1:0] r;
        begin
            if (&v)
            begin
                r = v;
            end
            else
            begin
                r = v + 1'b1;
            end
            return r;
        end
    endfunction

    logic [bcf_pkg::COUNT_BITS-1:0] a_reg, c_reg, g_reg, t_reg, n_reg, len_reg;
    logic [bcf_pkg::COUNT_BITS-1:0] a_next, c_next, g_next, t_next, n_next, len_next;
    base_class_t cls;
    logic        accept;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign push     = accept && seq_end;

    always_comb
    begin
        case (base_char)
            CH_A_LO, CH_A_UP: cls = CLS_A;
            CH_C_LO, CH_C_UP: cls = CLS_C;
            CH_G_LO, CH_G_UP: cls = CLS_G;
            CH_T_LO, CH_T_UP: cls = CLS_T;
            CH_N_LO, CH_N_UP: cls = CLS_N;
            default:          cls = CLS_OTHER;
        endcase
    end

    // Tallies including the current character
    always_comb
    begin
        a_next   = (cls == CLS_A) ? sat_inc(a_reg) : a_reg;
        c_next   = (cls == CLS_C) ? sat_inc(c_reg) : c_reg;
        g_next   = (cls == CLS_G) ? sat_inc(g_reg) : g_reg;
        t_next   = (cls == CLS_T) ? sat_inc(t_reg) : t_reg;
        n_next   = (cls == CLS_N) ? sat_inc(n_reg) : n_reg;
        len_next = sat_inc(len_reg);

        push_data.len = len_next;
        push_data.a   = a_next;
        push_data.c   = c_next;
        push_data.g   = g_next;
        push_data.t   = t_next;
        push_data.n   = n_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            c_reg   <= '0;
            g_reg   <= '0;
            t_reg   <= '0;
            n_reg   <= '0;
            len_reg <= '0;
        end
        else if (accept)
        begin
            if (seq_end)
            begin
                // Start the next sequence from zero
                a_reg   <= '0;
                c_reg   <= '0;
                g_reg   <= '0;
                t_reg   <= '0;
                n_reg   <= '0;
                len_reg <= '0;
            end
            else
            begin
                a_reg   <= a_next;
                c_reg   <= c_next;
                g_reg   <= g_next;
                t_reg   <= t_next;
                n_reg   <= n_next;
                len_reg <= len_next;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/bcf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_queue
// Small FIFO of finished tally records between the front and back ends.
// ----------------------------------------------------------------------------
module bcf_queue
(
    input  wire  logic                  clk,
    input  wire  logic                  rst_n,
    input  wire  logic                  push,
    input  wire  bcf_pkg::tally_snap_t  push_data,
    input  wire  logic                  pop,
    output bcf_pkg::tally_snap_t        pop_data,
    output bcf_pkg::q_stat_t            q_stat
);

    bcf_pkg::tally_snap_t mem [bcf_pkg::QDEPTH];

    logic [bcf_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [bcf_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push, do_pop;

    assign q_stat.full  = (count_reg == bcf_pkg::QCNT_W'(bcf_pkg::QDEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

### hdl/bcf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_back
// Two-stage test pipeline: scale the cutoffs by the length, then compare the
// four base counts against both bounds and hold the result for the receiver.
// ----------------------------------------------------------------------------
module bcf_back
(
    input  wire  logic                          clk,
    input  wire  logic                          rst_n,
    input  wire  bcf_pkg::q_stat_t              q_stat,
    input  wire  bcf_pkg::tally_snap_t          pop_data,
    output logic                                pop,
    input  wire  logic [bcf_pkg::CUT_W-1:0]     lo_bound,
    input  wire  logic [bcf_pkg::CUT_W-1:0]     hi_bound,
    input  wire  logic [bcf_pkg::LEN_W-1:0]     min_length,
    output logic                                out_valid,
    input  wire  logic                          out_stall,
    output logic                                keep,
    output logic                                too_short,
    output logic [bcf_pkg::OUT_W-1:0]           seq_length,
    output logic [bcf_pkg::OUT_W-1:0]           count_a,
    output logic [bcf_pkg::OUT_W-1:0]           count_c,
    output logic [bcf_pkg::OUT_W-1:0]           count_g,
    output logic [bcf_pkg::OUT_W-1:0]           count_t,
    output logic [bcf_pkg::OUT_W-1:0]           count_n
);

    typedef struct packed {
        logic                           too_short;
        bcf_pkg::tally_snap_t           tally;
        logic [bcf_pkg::PROD_W-1:0]     prod_lo;
        logic [bcf_pkg::PROD_W-1:0]     prod_hi;
    } s1_t;

    function automatic logic frac_ok(
        input logic [bcf_pkg::COUNT_BITS-1:0] cnt,
        input logic [bcf_pkg::PROD_W-1:0]     lo,
        input logic [bcf_pkg::PROD_W-1:0]     hi
    );
        logic [bcf_pkg::PROD_W-1:0] scaled;
        begin
            scaled = {cnt, {bcf_pkg::CUT_W{1'b0}}};
            return (scaled > lo) && (scaled < hi);
        end
    endfunction

    s1_t  s1_reg, s1_next;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic keep_reg, too_short_reg;
    logic [bcf_pkg::OUT_W-1:0] len_reg, a_reg, c_reg, g_reg, t_reg, n_reg;
    logic keep_next;
    logic out_ready, s1_load;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_load   = !s1_valid_reg || out_ready;
    assign pop       = s1_load && !q_stat.empty;

    // Stage 1: cutoff times length, length test
    always_comb
    begin
        s1_next.tally     = pop_data;
        s1_next.too_short = bcf_pkg::CMP_W'(pop_data.len) <= bcf_pkg::CMP_W'(min_length);
        s1_next.prod_lo   = bcf_pkg::PROD_W'(lo_bound) * bcf_pkg::PROD_W'(pop_data.len);
        s1_next.prod_hi   = bcf_pkg::PROD_W'(hi_bound) * bcf_pkg::PROD_W'(pop_data.len);
    end

    // Stage 2: keep when long enough and all four fractions strictly inside the bounds
    always_comb
    begin
        keep_next = !s1_reg.too_short
                    && frac_ok(s1_reg.tally.a, s1_reg.prod_lo, s1_reg.prod_hi)
                    && frac_ok(s1_reg.tally.c, s1_reg.prod_lo, s1_reg.prod_hi)
                    && frac_ok(s1_reg.tally.g, s1_reg.prod_lo, s1_reg.prod_hi)
                    && frac_ok(s1_reg.tally.t, s1_reg.prod_lo, s1_reg.prod_hi);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg <= s1_next;
        end
        if (out_ready && s1_valid_reg)
        begin
            keep_reg      <= keep_next;
            too_short_reg <= s1_reg.too_short;
            len_reg       <= bcf_pkg::OUT_W'(s1_reg.tally.len);
            a_reg         <= bcf_pkg::OUT_W'(s1_reg.tally.a);
            c_reg         <= bcf_pkg::OUT_W'(s1_reg.tally.c);
            g_reg         <= bcf_pkg::OUT_W'(s1_reg.tally.g);
            t_reg         <= bcf_pkg::OUT_W'(s1_reg.tally.t);
            n_reg         <= bcf_pkg::OUT_W'(s1_reg.tally.n);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= !q_stat.empty;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign keep       = keep_reg;
    assign too_short  = too_short_reg;
    assign seq_length = len_reg;
    assign count_a    = a_reg;
    assign count_c    = c_reg;
    assign count_g    = g_reg;
    assign count_t    = t_reg;
    assign count_n    = n_reg;

endmodule
`default_nettype wire

### hdl/base_composition_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base_composition_filter_core
// Per-sequence nucleotide composition filter with saturating base tallies.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one character beat per cycle,
//   base_char plus seq_end on the last character of a sequence. A beat moves
//   when in_valid is high and in_stall low.
//   Output channel (out_valid / out_stall): one result beat per sequence with
//   keep, too_short, the length and the A/C/G/T/N counts.
//   Config channel (cfg_valid / cfg_ready): cfg_index 0 = lower fraction
//   bound, 1 = upper fraction bound, 2 = minimum length; other indexes are
//   dropped. Write only while the block is idle.
//   Throughput: one character per cycle while in_stall is low, set by the
//   tally update in the front end; the back end takes one result per cycle
//   while the output is not stalled. Path: the tallies of the last character
//   pass through the queue, the stage 1 register and the result register.
//   Stall: out_stall holds the result register; the back pipeline and then
//   the four-entry tally queue fill, and in_stall rises only when the
//   queue is full.
//   Reset: tallies clear, the queue empties, registers return to 0.15, 0.40
//   and 1000.
// ----------------------------------------------------------------------------
module base_composition_filter_core
(
    input  wire  logic                          clk,
    input  wire  logic                          rst_n,
    // Character channel
    input  wire  logic                          in_valid,
    output logic                                in_stall,
    input  wire  logic [7:0]                    base_char,
    input  wire  logic                          seq_end,
    // Result channel
    output logic                                out_valid,
    input  wire  logic                          out_stall,
    output logic                                keep,
    output logic                                too_short,
    output logic [bcf_pkg::OUT_W-1:0]           seq_length,
    output logic [bcf_pkg::OUT_W-1:0]           count_a,
    output logic [bcf_pkg::OUT_W-1:0]           count_c,
    output logic [bcf_pkg::OUT_W-1:0]           count_g,
    output logic [bcf_pkg::OUT_W-1:0]           count_t,
    output logic [bcf_pkg::OUT_W-1:0]           count_n,
    // Config write channel
    input  wire  logic                          cfg_valid,
    output logic                                cfg_ready,
    input  wire  logic [bcf_pkg::IDX_W-1:0]     cfg_index,
    input  wire  logic [bcf_pkg::CFG_W-1:0]     cfg_data
);

    logic [bcf_pkg::CUT_W-1:0] lo_bound_reg, hi_bound_reg;
    logic [bcf_pkg::LEN_W-1:0] min_length_reg;

    bcf_pkg::q_stat_t     q_stat;
    bcf_pkg::tally_snap_t push_data, pop_data;
    logic                 push, pop;

    // Registers take a write every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_bound_reg   <= bcf_pkg::LO_BOUND_RST;
            hi_bound_reg   <= bcf_pkg::HI_BOUND_RST;
            min_length_reg <= bcf_pkg::MIN_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bcf_pkg::REG_LO_BOUND:   lo_bound_reg   <= cfg_data[bcf_pkg::CUT_W-1:0];
                bcf_pkg::REG_HI_BOUND:   hi_bound_reg   <= cfg_data[bcf_pkg::CUT_W-1:0];
                bcf_pkg::REG_MIN_LENGTH: min_length_reg <= cfg_data[bcf_pkg::LEN_W-1:0];
                default:                 ; // unmapped index: drop the beat
            endcase
        end
    end

    // Front: classify and count, push finished tallies
    bcf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base_char (base_char),
        .seq_end   (seq_end),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // Decouple counting from testing
    bcf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // Back: fraction and length tests, result register
    bcf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .pop_data    (pop_data),
        .pop         (pop),
        .lo_bound    (lo_bound_reg),
        .hi_bound    (hi_bound_reg),
        .min_length  (min_length_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .keep        (keep),
        .too_short   (too_short),
        .seq_length  (seq_length),
        .count_a     (count_a),
        .count_c     (count_c),
        .count_g     (count_g),
        .count_t     (count_t),
        .count_n     (count_n)
    );

endmodule
`default_nettype wire

### hdl/bcf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcf_checker
// Port-level checks on the result channel of the composition filter.
// ----------------------------------------------------------------------------
module bcf_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic                          keep,
    input  wire logic                          too_short,
    input  wire logic [bcf_pkg::OUT_W-1:0]     seq_length,
    input  wire logic [bcf_pkg::OUT_W-1:0]     count_a,
    input  wire logic [bcf_pkg::OUT_W-1:0]     count_c,
    input  wire logic [bcf_pkg::OUT_W-1:0]     count_g,
    input  wire logic [bcf_pkg::OUT_W-1:0]     count_t
);

    localparam bit NARROW = (bcf_pkg::COUNT_BITS <= bcf_pkg::OUT_W);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(keep) && $stable(seq_length))
        else $error("result beat changed while stalled");

    // A short sequence is never kept
    a_keep_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(keep && too_short))
        else $error("keep and too_short both set");

    // No A, C, G or T count exceeds the length
    a_count_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && NARROW |-> count_a <= seq_length && count_c <= seq_length
                                && count_g <= seq_length && count_t <= seq_length)
        else $error("base count above sequence length");

    // A kept sequence has A, C, G and T all present
    a_keep_bases: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && keep && NARROW |-> count_a != 0 && count_c != 0
                                        && count_g != 0 && count_t != 0)
        else $error("kept sequence with a missing base");

endmodule

bind base_composition_filter_core bcf_checker u_bcf_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .keep       (keep),
    .too_short  (too_short),
    .seq_length (seq_length),
    .count_a    (count_a),
    .count_c    (count_c),
    .count_g    (count_g),
    .count_t    (count_t)
);
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: base composition filter core
// Streams character beats through the core and checks every result beat
// against a cycle-free predictor of the A/C/G/T/N tallies and the fraction
// tests. A short directed table runs first, then random sequences under
// several register settings and three idle/stall profiles.
// ----------------------------------------------------------------------------
module testbench;

    // Cycles to hold after the last result before a register write
    localparam int SETTLE_CYCLES = 4;
    // Cycles to hold at the end for stray result beats
    localparam int TAIL_CYCLES   = 10;
    // Quiet cycles (no beat moving on any channel) before giving up
    localparam int QUIET_LIMIT   = 2000;
    // Characters and sequences per random phase, at least
    localparam int PHASE_CHARS   = 140;
    localparam int PHASE_SEQS    = 10;
    // Index with no register behind it
    localparam logic [bcf_pkg::IDX_W-1:0] REG_UNMAPPED = 2'd3;

    // One result beat as the core presents it
    typedef struct packed {
        logic                      keep;
        logic                      too_short;
        logic [bcf_pkg::OUT_W-1:0] len;
        logic [bcf_pkg::OUT_W-1:0] a;
        logic [bcf_pkg::OUT_W-1:0] c;
        logic [bcf_pkg::OUT_W-1:0] g;
        logic [bcf_pkg::OUT_W-1:0] t;
        logic [bcf_pkg::OUT_W-1:0] n;
    } verdict_t;

    typedef enum {ROW_BEAT, ROW_CFG} row_kind_t;

    // One row of the directed table: either a character beat or a register write
    typedef struct {
        row_kind_t                 kind;
        logic [bcf_pkg::IDX_W-1:0] idx;
        logic [bcf_pkg::CFG_W-1:0] data;
        logic [7:0]                ch;
        logic                      last;
        bit                        typed;
        verdict_t                  want;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [7:0]                base_char;
    logic                      seq_end;
    logic                      out_valid;
    logic                      out_stall;
    logic                      keep;
    logic                      too_short;
    logic [bcf_pkg::OUT_W-1:0] seq_length;
    logic [bcf_pkg::OUT_W-1:0] count_a;
    logic [bcf_pkg::OUT_W-1:0] count_c;
    logic [bcf_pkg::OUT_W-1:0] count_g;
    logic [bcf_pkg::OUT_W-1:0] count_t;
    logic [bcf_pkg::OUT_W-1:0] count_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [bcf_pkg::IDX_W-1:0] cfg_index;
    logic [bcf_pkg::CFG_W-1:0] cfg_data;

    // Predictor copy of the registers and the running tallies
    logic [bcf_pkg::CUT_W-1:0]      cut_lo;
    logic [bcf_pkg::CUT_W-1:0]      cut_hi;
    logic [bcf_pkg::LEN_W-1:0]      min_len;
    logic [bcf_pkg::COUNT_BITS-1:0] run_a, run_c, run_g, run_t, run_n, run_len;

    // Results owed by the core, oldest first
    verdict_t verdicts_due[$];

    plan_row_t plan[$];

    int gap_pct;
    int stall_pct;
    int errors;
    int chars_sent;
    int seqs_sent;
    int kept_due;
    int reg_writes;

    base_composition_filter_core u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .base_char  (base_char),
        .seq_end    (seq_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .keep       (keep),
        .too_short  (too_short),
        .seq_length (seq_length),
        .count_a    (count_a),
        .count_c    (count_c),
        .count_g    (count_g),
        .count_t    (count_t),
        .count_n    (count_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 20 ns period, first rising edge at 10 ns
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic flag(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        errors++;
    endtask

    task automatic cmp_field(input string name, input logic [bcf_pkg::OUT_W-1:0] seen,
                             input logic [bcf_pkg::OUT_W-1:0] want);
        if (seen !== want)
            flag($sformatf("%s: got %0d, expected %0d", name, seen, want));
    endtask

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [bcf_pkg::COUNT_BITS-1:0] sat_bump(
        input logic [bcf_pkg::COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // count/len strictly inside (cut_lo, cut_hi), done as count*2^16 vs cutoff*len
    function automatic bit band_ok(input logic [bcf_pkg::COUNT_BITS-1:0] count,
                                   input logic [bcf_pkg::COUNT_BITS-1:0] len);
        logic [63:0] scaled;
        logic [63:0] lo_lim;
        logic [63:0] hi_lim;
        scaled = 64'(count) << 16;
        lo_lim = 64'(cut_lo) * 64'(len);
        hi_lim = 64'(cut_hi) * 64'(len);
        return (scaled > lo_lim) && (scaled < hi_lim);
    endfunction

    // Fold one accepted character into the tallies; on the last one, judge
    // the sequence and clear the tallies.
    task automatic absorb_base(input logic [7:0] ch, input logic last,
                               output bit done, output verdict_t v);
        bit shorty;
        case (ch)
            "a", "A": run_a = sat_bump(run_a);
            "c", "C": run_c = sat_bump(run_c);
            "g", "G": run_g = sat_bump(run_g);
            "t", "T": run_t = sat_bump(run_t);
            "n", "N": run_n = sat_bump(run_n);
            default: ;
        endcase
        run_len = sat_bump(run_len);
        done = last;
        v = '0;
        if (last)
        begin
            shorty      = 64'(run_len) <= 64'(min_len);
            v.too_short = shorty;
            v.keep      = !shorty && band_ok(run_a, run_len) && band_ok(run_c, run_len)
                          && band_ok(run_g, run_len) && band_ok(run_t, run_len);
            v.len       = bcf_pkg::OUT_W'(run_len);
            v.a         = bcf_pkg::OUT_W'(run_a);
            v.c         = bcf_pkg::OUT_W'(run_c);
            v.g         = bcf_pkg::OUT_W'(run_g);
            v.t         = bcf_pkg::OUT_W'(run_t);
            v.n         = bcf_pkg::OUT_W'(run_n);
            run_a = '0; run_c = '0; run_g = '0; run_t = '0; run_n = '0; run_len = '0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers (all called at a rising edge, drive with nonblocking updates)
    // ------------------------------------------------------------------------

    // Present one character beat, hold it until accepted, then predict.
    // A typed expectation, where given, replaces the predicted one.
    task automatic send_beat(input logic [7:0] ch, input logic last,
                             input bit typed, input verdict_t want);
        bit       moved;
        bit       done;
        verdict_t pred;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        base_char <= ch;
        seq_end   <= last;
        // Sample in_stall mid-cycle: it is settled there and holds to the edge
        do
        begin
            @(negedge clk);
            moved = !in_stall;
            @(posedge clk);
        end
        while (!moved);
        chars_sent++;
        absorb_base(ch, last, done, pred);
        if (done)
        begin
            if (typed)
                pred = want;
            verdicts_due.push_back(pred);
            seqs_sent++;
            if (pred.keep)
                kept_due++;
        end
    endtask

    // Write one register; the predictor takes the value at the accepting edge.
    task automatic write_reg(input logic [bcf_pkg::IDX_W-1:0] idx,
                             input logic [bcf_pkg::CFG_W-1:0] data);
        bit moved;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            moved = cfg_ready;
            @(posedge clk);
        end
        while (!moved);
        case (idx)
            bcf_pkg::REG_LO_BOUND:   cut_lo  = data[bcf_pkg::CUT_W-1:0];
            bcf_pkg::REG_HI_BOUND:   cut_hi  = data[bcf_pkg::CUT_W-1:0];
            bcf_pkg::REG_MIN_LENGTH: min_len = data[bcf_pkg::LEN_W-1:0];
            default: ;       // unmapped index: the core drops it
        endcase
        reg_writes++;
        // Drop valid for one edge so back-to-back writes never re-raise it
        // in the same step
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Idle the character channel and wait until every owed result has left,
    // then wait out SETTLE_CYCLES for the back pipeline to empty.
    task automatic drain_to_idle();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pick a register setting: mostly useful bands with short minimums, plus
    // fully random and extreme corners.
    task automatic pick_settings();
        logic [bcf_pkg::CUT_W-1:0] lo;
        logic [bcf_pkg::CUT_W-1:0] hi;
        logic [bcf_pkg::LEN_W-1:0] ml;
        case ($urandom_range(4))
            0, 1:
            begin
                lo = bcf_pkg::CUT_W'($urandom_range(8000));
                hi = bcf_pkg::CUT_W'($urandom_range(65535, 30000));
                ml = $urandom_range(12);
            end
            2:
            begin
                lo = bcf_pkg::CUT_W'($urandom_range(65535));
                hi = bcf_pkg::CUT_W'($urandom_range(65535));
                ml = $urandom_range(40);
            end
            3:
            begin
                lo = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                hi = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                ml = $urandom_range(3) == 0 ? 32'hFFFF_FFFF : 32'd0;
            end
            default:
            begin
                lo = bcf_pkg::LO_BOUND_RST;
                hi = bcf_pkg::HI_BOUND_RST;
                ml = $urandom_range(20);
            end
        endcase
        write_reg(bcf_pkg::REG_LO_BOUND, bcf_pkg::CFG_W'(lo));
        write_reg(bcf_pkg::REG_HI_BOUND, bcf_pkg::CFG_W'(hi));
        write_reg(bcf_pkg::REG_MIN_LENGTH, bcf_pkg::CFG_W'(ml));
    endtask

    // One random sequence: mostly short, balanced or skewed bases with mixed
    // case; some sequences are plain byte noise.
    task automatic send_random_seq();
        string      bases;
        int         len;
        int         style;
        int         fav;
        logic [7:0] ch;
        verdict_t   none;
        bases = "ACGTNacgtn";
        none  = '0;
        len   = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
        style = $urandom_range(5);
        fav   = $urandom_range(9);
        for (int i = 0; i < len; i++)
        begin
            if (style == 0 || $urandom_range(19) == 0)
                ch = 8'($urandom_range(255));
            else if (style == 1 && $urandom_range(1))
                ch = bases[fav];
            else
                ch = bases[$urandom_range(9)];
            send_beat(ch, i == len - 1, 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, sample mid-cycle, check at the edge
    // ------------------------------------------------------------------------
    initial
    begin
        verdict_t seen;
        verdict_t want;
        bit       moved;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            moved = (rst_n === 1'b1) && (out_valid === 1'b1) && !out_stall;
            seen  = '{keep, too_short, seq_length, count_a, count_c, count_g,
                      count_t, count_n};
            @(posedge clk);
            if (moved)
            begin
                if (verdicts_due.size() == 0)
                    flag($sformatf("result beat with nothing owed (length %0d)", seen.len));
                else
                begin
                    want = verdicts_due.pop_front();
                    cmp_field("keep", bcf_pkg::OUT_W'(seen.keep),
                              bcf_pkg::OUT_W'(want.keep));
                    cmp_field("too_short", bcf_pkg::OUT_W'(seen.too_short),
                              bcf_pkg::OUT_W'(want.too_short));
                    cmp_field("seq_length", seen.len, want.len);
                    cmp_field("count_a", seen.a, want.a);
                    cmp_field("count_c", seen.c, want.c);
                    cmp_field("count_g", seen.g, want.g);
                    cmp_field("count_t", seen.t, want.t);
                    cmp_field("count_n", seen.n, want.n);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: give up after a long stretch with no beat on any channel
    // ------------------------------------------------------------------------
    initial
    begin
        int  quiet;
        bit  moving;
        quiet = 0;
        forever
        begin
            @(negedge clk);
            moving = (in_valid && !in_stall) || (out_valid && !out_stall)
                     || (cfg_valid && cfg_ready);
            @(posedge clk);
            if (moving || rst_n !== 1'b1)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Watchdog: %0d cycles without a beat, %0d results owed",
                         quiet, verdicts_due.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------------
    function automatic verdict_t verdict(input logic k, input logic s,
                                         input int unsigned len, input int unsigned a,
                                         input int unsigned c, input int unsigned g,
                                         input int unsigned t, input int unsigned n);
        verdict_t v;
        v = '{k, s, bcf_pkg::OUT_W'(len), bcf_pkg::OUT_W'(a), bcf_pkg::OUT_W'(c),
              bcf_pkg::OUT_W'(g), bcf_pkg::OUT_W'(t), bcf_pkg::OUT_W'(n)};
        return v;
    endfunction

    function automatic void beat_row(input logic [7:0] ch, input logic last);
        plan_row_t r;
        r       = '{kind: ROW_BEAT, idx: '0, data: '0, ch: ch, last: last,
                    typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    function automatic void end_row(input logic [7:0] ch, input verdict_t want);
        plan_row_t r;
        r       = '{kind: ROW_BEAT, idx: '0, data: '0, ch: ch, last: 1'b1,
                    typed: 1'b1, want: want};
        plan.push_back(r);
    endfunction

    function automatic void cfg_row(input logic [bcf_pkg::IDX_W-1:0] idx,
                                    input logic [bcf_pkg::CFG_W-1:0] data);
        plan_row_t r;
        r       = '{kind: ROW_CFG, idx: idx, data: data, ch: '0, last: 1'b0,
                    typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int gap_by_phase[3];
        int stall_by_phase[3];
        int phase_chars;
        int phase_seqs;

        gap_by_phase   = '{7, 57, 0};
        stall_by_phase = '{57, 7, 0};

        // Hold every input at a known value from time zero
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        base_char = '0;
        seq_end   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gap_pct   = 0;
        stall_pct = 0;
        errors     = 0;
        chars_sent = 0;
        seqs_sent  = 0;
        kept_due   = 0;
        reg_writes = 0;

        cut_lo  = bcf_pkg::LO_BOUND_RST;
        cut_hi  = bcf_pkg::HI_BOUND_RST;
        min_len = bcf_pkg::MIN_LENGTH_RST;
        run_a = '0; run_c = '0; run_g = '0; run_t = '0; run_n = '0; run_len = '0;

        // Reset values: a lone character is far below the 1000 minimum
        end_row("A", verdict(1'b0, 1'b1, 1, 1, 0, 0, 0, 0));
        cfg_row(bcf_pkg::REG_MIN_LENGTH, 32'd3);
        // Even ACGT mix, mixed case: each fraction 0.25 sits inside 0.15..0.40
        beat_row("a", 1'b0);
        beat_row("C", 1'b0);
        beat_row("g", 1'b0);
        beat_row("T", 1'b1);
        // Length equal to the minimum is still too short
        beat_row("A", 1'b0);
        beat_row("c", 1'b0);
        beat_row("t", 1'b1);
        // Non-base bytes count toward length only; N in both cases
        beat_row(8'h00, 1'b0);
        beat_row("N", 1'b0);
        beat_row("n", 1'b0);
        end_row(8'hFF, verdict(1'b0, 1'b0, 4, 0, 0, 0, 0, 2));
        // Inverted cutoffs at the extremes: nothing can pass
        cfg_row(bcf_pkg::REG_LO_BOUND, 32'h0000_FFFF);
        cfg_row(bcf_pkg::REG_HI_BOUND, 32'h0000_0000);
        beat_row("A", 1'b0);
        beat_row("C", 1'b0);
        beat_row("G", 1'b0);
        beat_row("T", 1'b0);
        end_row("A", verdict(1'b0, 1'b0, 5, 2, 1, 1, 1, 0));
        // Widest band, zero minimum: a single G fails on the empty A fraction
        cfg_row(bcf_pkg::REG_LO_BOUND, 32'h0000_0000);
        cfg_row(bcf_pkg::REG_HI_BOUND, 32'h0000_FFFF);
        cfg_row(bcf_pkg::REG_MIN_LENGTH, 32'h0000_0000);
        end_row("G", verdict(1'b0, 1'b0, 1, 0, 0, 1, 0, 0));
        beat_row("g", 1'b0);
        beat_row("t", 1'b0);
        beat_row("C", 1'b0);
        beat_row("a", 1'b1);
        // Unmapped index is dropped; then the largest minimum
        cfg_row(REG_UNMAPPED, 32'hA5A5_5A5A);
        cfg_row(bcf_pkg::REG_MIN_LENGTH, 32'hFFFF_FFFF);
        end_row("c", verdict(1'b0, 1'b1, 1, 0, 1, 0, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                drain_to_idle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_beat(plan[i].ch, plan[i].last, plan[i].typed, plan[i].want);
        end

        // Random part: three idle profiles, settings changed every few sequences
        for (int p = 0; p < 3; p++)
        begin
            drain_to_idle();
            gap_pct     = gap_by_phase[p];
            stall_pct   = stall_by_phase[p];
            phase_chars = chars_sent;
            phase_seqs  = 0;
            while (chars_sent - phase_chars < PHASE_CHARS || phase_seqs < PHASE_SEQS)
            begin
                if (phase_seqs % 5 == 0)
                begin
                    drain_to_idle();
                    pick_settings();
                end
                send_random_seq();
                phase_seqs++;
            end
        end

        drain_to_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        while (verdicts_due.size() != 0)
        begin
            void'(verdicts_due.pop_front());
            flag("result still owed at end of run");
        end

        $display("Covered %0d characters in %0d sequences (%0d expected kept)",
                 chars_sent, seqs_sent, kept_due);
        $display("with %0d register writes and three idle/stall profiles", reg_writes);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### base_composition_filter_core.f
hdl/bcf_pkg.sv
hdl/bcf_front.sv
hdl/bcf_queue.sv
hdl/bcf_back.sv
hdl/base_composition_filter_core.sv
hdl/bcf_checker.sv
verif/testbench.sv
